// ----- hw/rtl/mlqs_pkg.sv -----
// shared types and constants for the multilevel queue scheduler
package mlqs_pkg;

  typedef struct packed {
    logic [15:0] rem;
    logic [7:0]  prio;
    logic [7:0]  id;
  } entry_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_PRIO = 2'd1,
    MODE_RR   = 2'd2
  } run_mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } pq_ctl_t;

  typedef struct packed {
    logic pop;
    logic push;
  } rq_ctl_t;

  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam logic [7:0] QUANTUM_RESET = 8'd2;

endpackage

// ----- hw/rtl/multilevel_queue_scheduler_unit.sv -----
// top level of the two-level priority / round-robin process scheduler
//
//   channel  | handshake            | beat
//   ---------+----------------------+--------------------------------------------
//   input    | start / busy         | in_func, in_proc_id, in_priority_req, in_burst
//   result   | out_valid (strobe)   | out_running_valid, out_running_id,
//            |                      | out_finished, out_arrival_refused
//   config   | cfg_valid / cfg_ready| cfg_quantum
//
// an accepted item is loaded into the item register; the execute state then updates the
// queue chains and the run state and registers the result beat.
// busy is high for the one execute cycle; out_valid follows in the next cycle, in which
// a new item may already be accepted.
// sync reset empties both queues and sets quantum to 2; no clearing pass.
// results cannot be stalled; cfg_ready is always high.
module multilevel_queue_scheduler_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [7:0]  in_proc_id,
  input  logic [7:0]  in_priority_req,
  input  logic [15:0] in_burst,
  output logic        out_valid,
  output logic        out_running_valid,
  output logic [7:0]  out_running_id,
  output logic        out_finished,
  output logic        out_arrival_refused,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_quantum
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  mlqs_pkg::ctl_state_t state_r, state_nxt;
  mlqs_pkg::run_mode_t  mode_r, mode_nxt;
  mlqs_pkg::entry_t     cur_r, cur_nxt;
  logic [7:0]           slice_r, slice_nxt;
  logic [7:0]           quantum_r;
  logic [CW-1:0]        pcount_r, pcount_nxt;
  logic [CW-1:0]        rcount_r, rcount_nxt;
  logic [CW-1:0]        pending_r, pending_nxt;

  logic                 func_r;
  mlqs_pkg::entry_t     item_r;

  logic                 out_valid_r, out_valid_nxt;
  logic                 res_valid_r, res_valid_nxt;
  logic [7:0]           res_id_r, res_id_nxt;
  logic                 res_fin_r, res_fin_nxt;
  logic                 res_ref_r, res_ref_nxt;

  mlqs_pkg::pq_ctl_t    pq_ctl;
  mlqs_pkg::rq_ctl_t    rq_ctl;
  mlqs_pkg::entry_t     rq_new;
  logic [IW-1:0]        rq_wr_pos;

  mlqs_pkg::entry_t     pq_entry [DEPTH];
  logic                 pq_le    [DEPTH];
  mlqs_pkg::entry_t     rq_entry [DEPTH];

  assign busy                = (state_r == mlqs_pkg::ST_EXEC);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_running_valid   = res_valid_r;
  assign out_running_id      = res_id_r;
  assign out_finished        = res_fin_r;
  assign out_arrival_refused = res_ref_r;

  assign rq_wr_pos = rq_ctl.pop ? IW'(rcount_r - CW'(1)) : IW'(rcount_r);

  // cell chains
  for (genvar g = 0; g < DEPTH; g++) begin : g_cells
    mlqs_pkg::entry_t p_prev, p_next, r_next;
    logic             p_prev_le;

    if (g == 0) begin : g_first
      assign p_prev    = item_r;
      assign p_prev_le = 1'b1;
    end else begin : g_mid
      assign p_prev    = pq_entry[g-1];
      assign p_prev_le = pq_le[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign p_next = pq_entry[g];
      assign r_next = rq_entry[g];
    end else begin : g_inner
      assign p_next = pq_entry[g+1];
      assign r_next = rq_entry[g+1];
    end

    mlqs_prio_cell #(.CW(CW), .IDX(g)) u_pcell (
      .clk        (clk),
      .ctl        (pq_ctl),
      .count      (pcount_r),
      .new_entry  (item_r),
      .prev_entry (p_prev),
      .prev_le    (p_prev_le),
      .next_entry (p_next),
      .entry      (pq_entry[g]),
      .le         (pq_le[g])
    );

    mlqs_rr_cell #(.IW(IW), .IDX(g)) u_rcell (
      .clk        (clk),
      .ctl        (rq_ctl),
      .wr_pos     (rq_wr_pos),
      .new_entry  (rq_new),
      .next_entry (r_next),
      .entry      (rq_entry[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cur_nxt       = cur_r;
    slice_nxt     = slice_r;
    pcount_nxt    = pcount_r;
    rcount_nxt    = rcount_r;
    pending_nxt   = pending_r;
    out_valid_nxt = 1'b0;
    res_valid_nxt = res_valid_r;
    res_id_nxt    = res_id_r;
    res_fin_nxt   = res_fin_r;
    res_ref_nxt   = res_ref_r;
    pq_ctl        = '0;
    rq_ctl        = '0;
    rq_new        = cur_r;

    unique case (state_r)
      mlqs_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = mlqs_pkg::ST_EXEC;
        end
      end
      mlqs_pkg::ST_EXEC: begin
        state_nxt     = mlqs_pkg::ST_IDLE;
        out_valid_nxt = 1'b1;
        res_valid_nxt = 1'b0;
        res_id_nxt    = 8'd0;
        res_fin_nxt   = 1'b0;
        res_ref_nxt   = 1'b0;
        if (func_r == mlqs_pkg::FUNC_ARRIVE) begin
          if (pending_r >= CW'(DEPTH)) begin
            res_ref_nxt = 1'b1;
          end else begin
            pq_ctl.ins  = 1'b1;
            pcount_nxt  = pcount_r + CW'(1);
            pending_nxt = pending_r + CW'(1);
          end
        end else begin
          // dispatch or preempt
          if (mode_r == mlqs_pkg::MODE_IDLE) begin
            if (pcount_r != '0) begin
              cur_nxt    = pq_entry[0];
              mode_nxt   = mlqs_pkg::MODE_PRIO;
              pq_ctl.pop = 1'b1;
            end else if (rcount_r != '0) begin
              cur_nxt    = rq_entry[0];
              mode_nxt   = mlqs_pkg::MODE_RR;
              slice_nxt  = quantum_r;
              rq_ctl.pop = 1'b1;
            end
          end else if (pcount_r != '0) begin
            if (mode_r == mlqs_pkg::MODE_RR ||
                pq_entry[0].prio < cur_r.prio) begin
              rq_ctl.push = 1'b1;
              rq_new      = cur_r;
              cur_nxt     = pq_entry[0];
              mode_nxt    = mlqs_pkg::MODE_PRIO;
              pq_ctl.pop  = 1'b1;
            end
          end
          // run one unit
          if (mode_nxt != mlqs_pkg::MODE_IDLE) begin
            res_valid_nxt = 1'b1;
            res_id_nxt    = cur_nxt.id;
            if (cur_nxt.rem <= 16'd1) begin
              res_fin_nxt = 1'b1;
              cur_nxt.rem = 16'd0;
              mode_nxt    = mlqs_pkg::MODE_IDLE;
              if (pending_r != '0) begin
                pending_nxt = pending_r - CW'(1);
              end
            end else begin
              cur_nxt.rem = cur_nxt.rem - 16'd1;
              if (mode_nxt == mlqs_pkg::MODE_RR) begin
                if (slice_nxt <= 8'd1) begin
                  slice_nxt   = 8'd0;
                  rq_ctl.push = 1'b1;
                  rq_new      = cur_nxt;
                  mode_nxt    = mlqs_pkg::MODE_IDLE;
                end else begin
                  slice_nxt = slice_nxt - 8'd1;
                end
              end
            end
          end
          pcount_nxt = pcount_r - CW'(pq_ctl.pop);
          rcount_nxt = rcount_r - CW'(rq_ctl.pop) + CW'(rq_ctl.push);
        end
      end
      default: state_nxt = mlqs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlqs_pkg::ST_IDLE;
      mode_r      <= mlqs_pkg::MODE_IDLE;
      cur_r       <= '0;
      slice_r     <= 8'd0;
      quantum_r   <= mlqs_pkg::QUANTUM_RESET;
      pcount_r    <= '0;
      rcount_r    <= '0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cur_r       <= cur_nxt;
      slice_r     <= slice_nxt;
      pcount_r    <= pcount_nxt;
      rcount_r    <= rcount_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        quantum_r <= cfg_quantum;
      end
    end
  end

  // item and result beat payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_r      <= in_func;
      item_r.id   <= in_proc_id;
      item_r.prio <= in_priority_req;
      item_r.rem  <= in_burst;
    end
    res_valid_r <= res_valid_nxt;
    res_id_r    <= res_id_nxt;
    res_fin_r   <= res_fin_nxt;
    res_ref_r   <= res_ref_nxt;
  end

endmodule

// ----- hw/rtl/mlqs_prio_cell.sv -----
// one slot of the sorted priority queue shift chain
module mlqs_prio_cell #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  mlqs_pkg::pq_ctl_t ctl,
  input  logic [CW-1:0]    count,
  input  mlqs_pkg::entry_t new_entry,
  input  mlqs_pkg::entry_t prev_entry,
  input  logic             prev_le,
  input  mlqs_pkg::entry_t next_entry,
  output mlqs_pkg::entry_t entry,
  output logic             le
);

  localparam logic [CW-1:0] MY_POS = CW'(IDX);

  mlqs_pkg::entry_t entry_r;
  mlqs_pkg::entry_t entry_nxt;

  // slot holds a live entry that sorts at or before the newcomer
  assign le    = (MY_POS < count) && (entry_r.prio <= new_entry.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.pop) begin
      entry_nxt = next_entry;
    end else if (ctl.ins && !le) begin
      entry_nxt = prev_le ? new_entry : prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- hw/rtl/mlqs_rr_cell.sv -----
// one slot of the round-robin fifo shift chain
module mlqs_rr_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  mlqs_pkg::rq_ctl_t ctl,
  input  logic [IW-1:0]    wr_pos,
  input  mlqs_pkg::entry_t new_entry,
  input  mlqs_pkg::entry_t next_entry,
  output mlqs_pkg::entry_t entry
);

  localparam logic [IW-1:0] MY_POS = IW'(IDX);

  mlqs_pkg::entry_t entry_r;
  mlqs_pkg::entry_t entry_nxt;

  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.pop) begin
      entry_nxt = next_entry;
    end
    if (ctl.push && (wr_pos == MY_POS)) begin
      entry_nxt = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- hw/rtl/mlqs_checker.sv -----
// port-level checks for the scheduler, bound to the top level
module mlqs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_running_valid,
  input logic [7:0] out_running_id,
  input logic       out_finished,
  input logic       out_arrival_refused
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("execute cycle not followed by result beat");

  a_strobe_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without preceding work");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_running_valid) |-> (!out_finished && out_running_id == 8'd0))
    else $error("idle result carries running data");

  a_refuse_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_arrival_refused) |-> !out_running_valid)
    else $error("refused arrival reports a running process");

endmodule

bind multilevel_queue_scheduler_unit mlqs_checker u_mlqs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .out_valid           (out_valid),
  .out_running_valid   (out_running_valid),
  .out_running_id      (out_running_id),
  .out_finished        (out_finished),
  .out_arrival_refused (out_arrival_refused)
);
